>>> rtl/core/ssdp_pkg.sv
// Shared types and constants for the structured-data parser.
// Token and phase codes, character constants and the queue entry format.
// No dependencies.
`default_nettype none
package ssdp_pkg;

	typedef enum logic [2:0] {
		TK_ID        = 3'd0,
		TK_NAME      = 3'd1,
		TK_VALUE     = 3'd2,
		TK_PARAM_END = 3'd3,
		TK_ELEM_END  = 3'd4,
		TK_OK        = 3'd5,
		TK_BAD       = 3'd6
	} token_kind_t;

	typedef enum logic [3:0] {
		PH_START       = 4'd0,
		PH_ID          = 4'd1,
		PH_NAME        = 4'd2,
		PH_EQ          = 4'd3,
		PH_VALUE       = 4'd4,
		PH_AFTER_VALUE = 4'd5,
		PH_BETWEEN     = 4'd6
	} phase_t;

	localparam logic [7:0] ChSpace  = 8'd32;
	localparam logic [7:0] ChFirst  = 8'd33;
	localparam logic [7:0] ChLast   = 8'd126;
	localparam logic [7:0] ChLBrack = 8'h5B;
	localparam logic [7:0] ChRBrack = 8'h5D;
	localparam logic [7:0] ChEq     = 8'h3D;
	localparam logic [7:0] ChQuote  = 8'h22;
	localparam logic [7:0] ChBslash = 8'h5C;
	localparam logic [7:0] ChDash   = 8'h2D;

	localparam int QueueDepth = 4;
	localparam int PtrW       = $clog2(QueueDepth);
	localparam int FillW      = $clog2(QueueDepth + 1);

	// Tokens caused by one byte: one or two
	typedef struct packed {
		logic        pair;
		token_kind_t kind0;
		logic [7:0]  byte0;
		token_kind_t kind1;
		logic [7:0]  byte1;
	} tok_bundle_t;

	function automatic logic is_name_char(input logic [7:0] c);
		return c >= ChFirst && c <= ChLast && c != ChEq && c != ChRBrack && c != ChQuote;
	endfunction

endpackage
`default_nettype wire

>>> rtl/core/syslog_structured_data_parser_top.sv
// Top level of the structured-data parser: front end, bundle queue, back end.
// Depends on ssdp_pkg, ssdp_front, ssdp_queue and ssdp_back.
`default_nettype none

// Takes one byte of a STRUCTURED-DATA field per cycle while the four-entry
// token queue has room; gives one token per cycle while out_ready is high.
// A byte makes zero, one or two tokens; a two-token byte holds its bundle at
// the queue head until both are taken, so the sustained rate is one byte per
// cycle until the queue fills, then set by the one-token-per-cycle drain.
// Bundles pass through the queue registers. On TK_BAD (malformed field) the
// consumer must drop every earlier token of that field (not enforced here).
module syslog_structured_data_parser_top #(
	parameter int MAX_NAME_LEN = 32
) (
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       in_valid,
	output logic            in_ready,
	input  wire logic [7:0] field_byte,
	input  wire logic       end_of_field,
	output logic            out_valid,
	input  wire logic       out_ready,
	output logic [2:0]      token_kind,
	output logic [7:0]      token_byte,
	output logic            run_last
);

	logic                  q_full;
	logic                  q_empty;
	logic                  push;
	logic                  pop;
	ssdp_pkg::tok_bundle_t push_data;
	ssdp_pkg::tok_bundle_t head;

	ssdp_front #(
		.MAX_NAME_LEN(MAX_NAME_LEN)
	) u_front (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (in_valid),
		.in_ready    (in_ready),
		.field_byte  (field_byte),
		.end_of_field(end_of_field),
		.q_full      (q_full),
		.push        (push),
		.push_data   (push_data)
	);

	ssdp_queue u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.push_data(push_data),
		.pop      (pop),
		.full     (q_full),
		.empty    (q_empty),
		.head     (head)
	);

	ssdp_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.empty     (q_empty),
		.head      (head),
		.pop       (pop),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.token_kind(token_kind),
		.token_byte(token_byte),
		.run_last  (run_last)
	);

endmodule
`default_nettype wire

>>> rtl/core/ssdp_front.sv
// Front end: accepts field bytes, runs the syntax state machine and builds
// the token bundle for each byte. Depends on ssdp_pkg.
`default_nettype none
module ssdp_front #(
	parameter int MAX_NAME_LEN = 32
) (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic                 in_valid,
	output logic                      in_ready,
	input  wire logic [7:0]           field_byte,
	input  wire logic                 end_of_field,
	input  wire logic                 q_full,
	output logic                      push,
	output ssdp_pkg::tok_bundle_t     push_data
);

	localparam logic [5:0] MaxLen = 6'(MAX_NAME_LEN);

	ssdp_pkg::phase_t phase_q, phase_d;
	logic [5:0]       len_q, len_d;
	logic             esc_q, esc_d;
	logic             err_q, err_d;

	logic                  accept;
	logic                  fail;
	logic                  dash_ok;
	logic                  can_grow;
	logic [1:0]            cnt;
	ssdp_pkg::tok_bundle_t bun;

	assign in_ready = ~q_full;
	assign accept   = in_valid & ~q_full;
	assign can_grow = len_q < MaxLen;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= ssdp_pkg::PH_START;
			len_q   <= '0;
			esc_q   <= 1'b0;
			err_q   <= 1'b0;
		end else if (accept) begin
			phase_q <= phase_d;
			len_q   <= len_d;
			esc_q   <= esc_d;
			err_q   <= err_d;
		end
	end

	always_comb begin
		phase_d = phase_q;
		len_d   = len_q;
		esc_d   = esc_q;
		fail    = 1'b0;
		dash_ok = 1'b0;
		cnt     = 2'd0;
		bun     = '{pair: 1'b0, kind0: ssdp_pkg::TK_OK, byte0: 8'd0,
			kind1: ssdp_pkg::TK_OK, byte1: 8'd0};
		if (!err_q) begin
			unique case (phase_q)
				ssdp_pkg::PH_START: begin
					if (field_byte == ssdp_pkg::ChLBrack) begin
						phase_d = ssdp_pkg::PH_ID;
						len_d   = '0;
					end else if (field_byte == ssdp_pkg::ChDash && end_of_field) begin
						dash_ok = 1'b1;
					end else begin
						fail = 1'b1;
					end
				end
				ssdp_pkg::PH_ID: begin
					if (field_byte == ssdp_pkg::ChSpace || field_byte == ssdp_pkg::ChRBrack) begin
						if (len_q == 6'd0) begin
							fail = 1'b1;
						end else if (field_byte == ssdp_pkg::ChSpace) begin
							phase_d = ssdp_pkg::PH_NAME;
							len_d   = '0;
						end else begin
							bun.kind0 = ssdp_pkg::TK_ELEM_END;
							cnt       = 2'd1;
							phase_d   = ssdp_pkg::PH_BETWEEN;
						end
					end else if (ssdp_pkg::is_name_char(field_byte) && can_grow) begin
						bun.kind0 = ssdp_pkg::TK_ID;
						bun.byte0 = field_byte;
						cnt       = 2'd1;
						len_d     = len_q + 6'd1;
					end else begin
						fail = 1'b1;
					end
				end
				ssdp_pkg::PH_NAME: begin
					if (field_byte == ssdp_pkg::ChEq) begin
						if (len_q == 6'd0) begin
							fail = 1'b1;
						end else begin
							phase_d = ssdp_pkg::PH_EQ;
						end
					end else if (ssdp_pkg::is_name_char(field_byte) && can_grow) begin
						bun.kind0 = ssdp_pkg::TK_NAME;
						bun.byte0 = field_byte;
						cnt       = 2'd1;
						len_d     = len_q + 6'd1;
					end else begin
						fail = 1'b1;
					end
				end
				ssdp_pkg::PH_EQ: begin
					if (field_byte == ssdp_pkg::ChQuote) begin
						phase_d = ssdp_pkg::PH_VALUE;
						esc_d   = 1'b0;
					end else begin
						fail = 1'b1;
					end
				end
				ssdp_pkg::PH_VALUE: begin
					if (esc_q) begin
						esc_d = 1'b0;
						if (field_byte != ssdp_pkg::ChQuote && field_byte != ssdp_pkg::ChBslash &&
							field_byte != ssdp_pkg::ChRBrack) begin
							bun.kind0 = ssdp_pkg::TK_VALUE;
							bun.byte0 = ssdp_pkg::ChBslash;
							bun.kind1 = ssdp_pkg::TK_VALUE;
							bun.byte1 = field_byte;
							cnt       = 2'd2;
						end else begin
							bun.kind0 = ssdp_pkg::TK_VALUE;
							bun.byte0 = field_byte;
							cnt       = 2'd1;
						end
					end else if (field_byte == ssdp_pkg::ChBslash) begin
						esc_d = 1'b1;
					end else if (field_byte == ssdp_pkg::ChQuote) begin
						bun.kind0 = ssdp_pkg::TK_PARAM_END;
						cnt       = 2'd1;
						phase_d   = ssdp_pkg::PH_AFTER_VALUE;
					end else begin
						bun.kind0 = ssdp_pkg::TK_VALUE;
						bun.byte0 = field_byte;
						cnt       = 2'd1;
					end
				end
				ssdp_pkg::PH_AFTER_VALUE: begin
					if (field_byte == ssdp_pkg::ChSpace) begin
						phase_d = ssdp_pkg::PH_NAME;
						len_d   = '0;
					end else if (field_byte == ssdp_pkg::ChRBrack) begin
						bun.kind0 = ssdp_pkg::TK_ELEM_END;
						cnt       = 2'd1;
						phase_d   = ssdp_pkg::PH_BETWEEN;
					end else begin
						fail = 1'b1;
					end
				end
				ssdp_pkg::PH_BETWEEN: begin
					if (field_byte == ssdp_pkg::ChLBrack) begin
						phase_d = ssdp_pkg::PH_ID;
						len_d   = '0;
					end else begin
						fail = 1'b1;
					end
				end
				default: begin
					fail = 1'b1;
				end
			endcase
		end
		err_d = err_q | fail;
		if (err_d) begin
			cnt = 2'd0;
		end
		if (end_of_field) begin
			if (!err_d && (dash_ok || phase_d == ssdp_pkg::PH_BETWEEN)) begin
				if (cnt == 2'd0) begin
					bun.kind0 = ssdp_pkg::TK_OK;
					bun.byte0 = 8'd0;
					cnt       = 2'd1;
				end else begin
					bun.kind1 = ssdp_pkg::TK_OK;
					bun.byte1 = 8'd0;
					cnt       = 2'd2;
				end
			end else begin
				bun.kind0 = ssdp_pkg::TK_BAD;
				bun.byte0 = 8'd0;
				cnt       = 2'd1;
			end
			phase_d = ssdp_pkg::PH_START;
			len_d   = '0;
			esc_d   = 1'b0;
			err_d   = 1'b0;
		end
		bun.pair = cnt == 2'd2;
	end

	assign push      = accept && cnt != 2'd0;
	assign push_data = bun;

endmodule
`default_nettype wire

>>> rtl/core/ssdp_queue.sv
// Short queue of token bundles between front and back ends.
// Register-based, depth from ssdp_pkg. Depends on ssdp_pkg.
`default_nettype none
module ssdp_queue (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  push,
	input  wire ssdp_pkg::tok_bundle_t push_data,
	input  wire logic                  pop,
	output logic                       full,
	output logic                       empty,
	output ssdp_pkg::tok_bundle_t      head
);

	ssdp_pkg::tok_bundle_t                entries_q [ssdp_pkg::QueueDepth];
	logic [ssdp_pkg::PtrW-1:0]            wr_ptr_q;
	logic [ssdp_pkg::PtrW-1:0]            rd_ptr_q;
	logic [ssdp_pkg::FillW-1:0]           fill_q;

	assign full  = fill_q == ssdp_pkg::FillW'(ssdp_pkg::QueueDepth);
	assign empty = fill_q == '0;
	assign head  = entries_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			entries_q[wr_ptr_q] <= push_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			fill_q   <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				fill_q <= fill_q + 1'b1;
			end else if (pop && !push) begin
				fill_q <= fill_q - 1'b1;
			end
		end
	end

endmodule
`default_nettype wire

>>> rtl/core/ssdp_back.sv
// Back end: walks head-bundle tokens onto the output one per cycle while
// out_ready is high, marks each byte's last token. Depends on ssdp_pkg.
`default_nettype none
module ssdp_back (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  empty,
	input  wire ssdp_pkg::tok_bundle_t head,
	output logic                       pop,
	output logic                       out_valid,
	input  wire logic                  out_ready,
	output logic [2:0]                 token_kind,
	output logic [7:0]                 token_byte,
	output logic                       run_last
);

	logic sel_q;
	logic take;

	assign out_valid = ~empty;
	assign take      = out_valid & out_ready;
	assign run_last  = sel_q | ~head.pair;
	assign pop       = take & run_last;

	always_comb begin
		if (sel_q) begin
			token_kind = head.kind1;
			token_byte = head.byte1;
		end else begin
			token_kind = head.kind0;
			token_byte = head.byte0;
		end
	end

	// advance to the second token, or drop the bundle after its last one
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sel_q <= 1'b0;
		end else if (take) begin
			sel_q <= ~run_last;
		end
	end

endmodule
`default_nettype wire
